// File: sv/dsm_pkg.sv
package dsm_pkg;

  localparam int MaxElements = 32;

  localparam logic [7:0] StarByte = 8'h2A;  // '*'
  localparam logic [7:0] AnyByte  = 8'h2E;  // '.'

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_SUBJECT = 2'd1,
    MODE_START   = 2'd2
  } mode_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_SWEEP = 1'b1
  } state_e;

  // Wavefront handed from one cell to the next.
  typedef struct packed {
    logic tok;    // sweep token
    logic carry;  // new match bit of the cell on the left
    logic prev;   // old match bit of the cell on the left
    logic res;    // match bit of the last used element, once passed
  } wave_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic       subj;      // sweep applies a subject byte, else rebuilds the empty row
    logic [7:0] subj_sym;  // subject byte of the sweep
    logic       sym_we;    // store a new element
    logic       star_we;   // mark an element starred
    logic [7:0] wr_sym;    // element byte to store
  } cell_ctl_t;

endpackage

// File: sv/dsm_in_if.sv
interface dsm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] symbol;
  logic       last;

  modport source (output valid, output mode, output symbol, output last, input ready);
  modport sink   (input valid, input mode, input symbol, input last, output ready);
endinterface

// File: sv/dsm_out_if.sv
interface dsm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_too_long;

  modport source (output valid, output matched, output pattern_too_long, input ready);
  modport sink   (input valid, input matched, input pattern_too_long, output ready);
endinterface

// File: sv/dsm_cell.sv
module dsm_cell #(
  parameter int MAX_ELEMENTS = dsm_pkg::MaxElements,
  parameter int IDX          = 0
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  dsm_pkg::cell_ctl_t                   ctl_i,
  input  logic [((MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1)-1:0] w_idx_i,
  input  logic [((MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1)-1:0] s_idx_i,
  input  logic [$clog2(MAX_ELEMENTS + 1)-1:0]  cnt_i,
  input  dsm_pkg::wave_t                       wave_i,
  output dsm_pkg::wave_t                       wave_o
);

  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  logic [7:0]     sym_q;
  logic           star_q;
  logic           row_q;
  logic           active;
  logic           is_last;
  logic           hit;
  logic           new_bit;
  logic           tok_q;
  logic           carry_q;
  logic           prev_q;
  logic           res_q;

  // element storage, written at request time
  always_ff @(posedge clk_i) begin
    if (ctl_i.sym_we && (w_idx_i == IW'(IDX))) begin
      sym_q  <= ctl_i.wr_sym;
      star_q <= 1'b0;
    end else if (ctl_i.star_we && (s_idx_i == IW'(IDX))) begin
      star_q <= 1'b1;
    end
  end

  always_comb begin
    active  = CW'(IDX) < cnt_i;
    is_last = cnt_i == CW'(IDX + 1);
    hit     = (sym_q == dsm_pkg::AnyByte) || (sym_q == ctl_i.subj_sym);
    if (!active) begin
      new_bit = 1'b0;
    end else if (ctl_i.subj) begin
      new_bit = star_q ? (wave_i.carry | (row_q & hit)) : (wave_i.prev & hit);
    end else begin
      new_bit = wave_i.carry & star_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= 1'b0;
      tok_q <= 1'b0;
    end else if (en_i) begin
      tok_q <= wave_i.tok;
      if (wave_i.tok) begin
        row_q <= new_bit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && wave_i.tok) begin
      carry_q <= new_bit;
      prev_q  <= row_q;
      res_q   <= is_last ? new_bit : wave_i.res;
    end
  end

  assign wave_o = '{tok: tok_q, carry: carry_q, prev: prev_q, res: res_q};

endmodule

// File: sv/dot_star_pattern_matcher.sv
// Dot-star pattern matcher.
// in_i carries requests: mode selects a pattern byte load, a subject byte or
// a subject restart; symbol is the byte; last closes the pattern on a load,
// so the next load starts a fresh one. res_o returns one result per subject
// byte or restart: matched is set when the subject so far matches the whole
// pattern, pattern_too_long when the pattern overflowed the element cells.
// Loads and the unused mode return nothing.
// Each pattern element lives in one cell of a chain. A request sends a token
// down the chain, one cell per cycle unless the chain is held, carrying the
// left neighbor's old and new match bits, so starred elements see the bit
// just computed to their left. A result is taken into the output register
// when the token comes out of the last cell, and in_i turns ready in the
// same cycle that the result turns valid, so a new request waits for the
// previous sweep to finish. The unused mode is taken without a sweep.
// Reset clears the element count, the overflow flag and the cells' match
// bits, sets bit zero of the row and closes the pattern; element bytes are
// not cleared, and only loaded elements are ever read.
// A result waits in the output register while in_i takes the next request;
// if that one is a subject byte or restart and reaches the end of the chain
// while res_o is still stalled, the whole chain holds until the result is taken.
module dot_star_pattern_matcher #(
  parameter int MAX_ELEMENTS = dsm_pkg::MaxElements
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  dsm_in_if.sink           in_i,
  dsm_out_if.source        res_o
);

  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  dsm_pkg::state_e    state_q, state_d;
  dsm_pkg::mode_e     mode;
  dsm_pkg::wave_t     waves [MAX_ELEMENTS + 1];
  dsm_pkg::wave_t     entry_q, entry_d;
  dsm_pkg::cell_ctl_t ctl;
  dsm_pkg::wave_t     exit_w;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] cnt_eff;
  logic [CW-1:0] cnt_m1;
  logic [IW-1:0] w_idx;
  logic [IW-1:0] s_idx;
  logic          ovf_q, ovf_d;
  logic          ovf_eff;
  logic          closed_q, closed_d;
  logic          row0_q, row0_d;
  logic          subj_q, subj_d;
  logic          resop_q, resop_d;
  logic [7:0]    sym_q, sym_d;
  logic          out_valid_q, out_valid_d;
  logic          matched_q, matched_d;
  logic          too_long_q, too_long_d;
  logic          in_acc;
  logic          start;
  logic          is_load;
  logic          is_star;
  logic          adv;
  logic          capture;
  logic [MAX_ELEMENTS:0] tok_vec;

  assign mode    = dsm_pkg::mode_e'(in_i.mode);
  assign in_acc  = in_i.valid && in_i.ready;
  assign exit_w  = waves[MAX_ELEMENTS];
  assign waves[0] = entry_q;

  // A pattern that was closed restarts on its next byte.
  assign cnt_eff = closed_q ? '0 : cnt_q;
  assign ovf_eff = closed_q ? 1'b0 : ovf_q;
  assign cnt_m1  = cnt_eff - CW'(1);
  assign w_idx   = cnt_eff[IW-1:0];
  assign s_idx   = cnt_m1[IW-1:0];
  assign is_star = in_i.symbol == dsm_pkg::StarByte;

  // Hold the chain only when a result arrives at a still-full output.
  assign adv     = !(exit_w.tok && resop_q && out_valid_q && !res_o.ready);
  assign capture = exit_w.tok && adv && resop_q;

  always_comb begin
    start       = 1'b0;
    is_load     = 1'b0;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    closed_d    = closed_q;
    row0_d      = row0_q;
    subj_d      = subj_q;
    resop_d     = resop_q;
    sym_d       = sym_q;
    ctl.sym_we  = 1'b0;
    ctl.star_we = 1'b0;
    ctl.wr_sym  = in_i.symbol;
    if (in_acc) begin
      unique case (mode)
        dsm_pkg::MODE_LOAD: begin
          start    = 1'b1;
          is_load  = 1'b1;
          closed_d = in_i.last;
          cnt_d    = cnt_eff;
          ovf_d    = ovf_eff;
          if (!ovf_eff) begin
            if (is_star) begin
              // leading star is dropped
              ctl.star_we = cnt_eff != '0;
            end else if (cnt_eff < CW'(MAX_ELEMENTS)) begin
              ctl.sym_we = 1'b1;
              cnt_d      = cnt_eff + CW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
        end
        dsm_pkg::MODE_SUBJECT, dsm_pkg::MODE_START: begin
          start = 1'b1;
        end
        default: begin
        end
      endcase
      if (start) begin
        subj_d  = mode == dsm_pkg::MODE_SUBJECT;
        resop_d = !is_load;
        sym_d   = in_i.symbol;
        row0_d  = mode != dsm_pkg::MODE_SUBJECT;
      end
    end
    ctl.subj     = subj_q;
    ctl.subj_sym = sym_q;
  end

  // Token entry: bit zero of the row leads the wavefront.
  always_comb begin
    entry_d       = entry_q;
    entry_d.tok   = start | (entry_q.tok & !adv);
    if (start) begin
      entry_d.carry = row0_d;
      entry_d.prev  = row0_q;
      entry_d.res   = row0_d;
    end
  end

  always_comb begin
    state_d = state_q;
    in_i.ready = state_q == dsm_pkg::ST_IDLE;
    unique case (state_q)
      dsm_pkg::ST_IDLE: begin
        if (start) begin
          state_d = dsm_pkg::ST_SWEEP;
        end
      end
      dsm_pkg::ST_SWEEP: begin
        if (exit_w.tok && adv) begin
          state_d = dsm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dsm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = capture | (out_valid_q & !res_o.ready);
    matched_d   = capture ? exit_w.res : matched_q;
    too_long_d  = capture ? ovf_q : too_long_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dsm_pkg::ST_IDLE;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      closed_q    <= 1'b1;
      row0_q      <= 1'b1;
      entry_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      closed_q    <= closed_d;
      row0_q      <= row0_d;
      entry_q     <= entry_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    subj_q        <= subj_d;
    resop_q       <= resop_d;
    sym_q         <= sym_d;
    matched_q     <= matched_d;
    too_long_q    <= too_long_d;
  end

  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    dsm_cell #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .IDX          (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .ctl_i   (ctl),
      .w_idx_i (w_idx),
      .s_idx_i (s_idx),
      .cnt_i   (cnt_q),
      .wave_i  (waves[i]),
      .wave_o  (waves[i + 1])
    );
  end

  for (genvar i = 0; i <= MAX_ELEMENTS; i++) begin : g_tok
    assign tok_vec[i] = waves[i].tok;
  end

  assign res_o.valid            = out_valid_q;
  assign res_o.matched          = matched_q;
  assign res_o.pattern_too_long = too_long_q;

  // at most one sweep in flight
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vec))
    else $error("more than one token in the cell chain");

  // no request is taken while a token is in the chain
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (tok_vec == '0))
    else $error("ready raised during a sweep");

  // overflow is only possible with every cell in use
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (cnt_q == CW'(MAX_ELEMENTS)))
    else $error("overflow flagged with free cells");

  // a new result only comes out of a sweep
  a_res_from_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    capture |-> (state_q == dsm_pkg::ST_SWEEP))
    else $error("result captured outside a sweep");

endmodule
